### rtl/core/mos6502_execute_unit_macros.svh
// Assertion macros shared by the execute unit RTL.
`ifndef MOS6502_EXECUTE_UNIT_MACROS_SVH
`define MOS6502_EXECUTE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check that is held off while reset is asserted.
`define EU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also runs during reset.
`define EU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define EU_ASSERT(lbl, prop, msg)
`define EU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/m65eu_pkg.sv
// Types, codes and helper functions for the 6502 execute unit.
package m65eu_pkg;

  typedef enum logic [5:0] {
    ACT_ADC = 6'd0,  ACT_SBC = 6'd1,  ACT_AND = 6'd2,  ACT_ORA = 6'd3,
    ACT_EOR = 6'd4,  ACT_BIT = 6'd5,  ACT_CMP = 6'd6,  ACT_CPX = 6'd7,
    ACT_CPY = 6'd8,  ACT_BRANCH = 6'd9, ACT_CLC = 6'd10, ACT_CLD = 6'd11,
    ACT_CLI = 6'd12, ACT_CLV = 6'd13, ACT_SEC = 6'd14, ACT_SED = 6'd15,
    ACT_SEI = 6'd16, ACT_JMP = 6'd17, ACT_JSR = 6'd18, ACT_RTS = 6'd19,
    ACT_RTI = 6'd20, ACT_LDA = 6'd21, ACT_LDX = 6'd22, ACT_LDY = 6'd23,
    ACT_PHA = 6'd24, ACT_PHP = 6'd25, ACT_PLA = 6'd26, ACT_PLP = 6'd27,
    ACT_STA = 6'd28, ACT_STX = 6'd29, ACT_STY = 6'd30, ACT_TAX = 6'd31,
    ACT_TAY = 6'd32, ACT_TSX = 6'd33, ACT_TXA = 6'd34, ACT_TXS = 6'd35,
    ACT_TYA = 6'd36, ACT_INC = 6'd37, ACT_INX = 6'd38, ACT_INY = 6'd39,
    ACT_DEC = 6'd40, ACT_DEX = 6'd41, ACT_DEY = 6'd42, ACT_ASL_A = 6'd43,
    ACT_LSR_A = 6'd44, ACT_ROL_A = 6'd45, ACT_ROR_A = 6'd46, ACT_ASL_M = 6'd47,
    ACT_LSR_M = 6'd48, ACT_ROL_M = 6'd49, ACT_ROR_M = 6'd50, ACT_NOP = 6'd51,
    ACT_BRK = 6'd52, ACT_LAX = 6'd53, ACT_SAX = 6'd54, ACT_DCP = 6'd55,
    ACT_ISB = 6'd56, ACT_RLA = 6'd57, ACT_RRA = 6'd58, ACT_SLO = 6'd59,
    ACT_SRE = 6'd60
  } action_e;

  typedef enum logic [1:0] {
    SH_ASL = 2'd0, SH_LSR = 2'd1, SH_ROL = 2'd2, SH_ROR = 2'd3
  } shift_e;

  // Status bit positions.
  localparam int unsigned FlagN = 7;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  // B and U as a mask, and the bits taken from a pulled status byte.
  localparam logic [7:0] BuMask     = 8'h30;
  localparam logic [7:0] PulledMask = 8'hCF;

  localparam logic [7:0] ResetFlags = 8'h24;
  localparam logic [7:0] ResetSp    = 8'hFD;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  // Input item, action in the lowest bits.
  typedef struct packed {
    logic [2:0] branch_condition;
    logic [7:0] operand;
    logic [5:0] action;
  } in_item_t;

  // Result item, write_data in the lowest bits.
  typedef struct packed {
    logic [7:0] sp_out;
    logic [7:0] flags_out;
    logic [7:0] y_out;
    logic [7:0] x_out;
    logic [7:0] acc_out;
    logic       branch_taken;
    logic       write_strobe;
    logic [7:0] write_data;
  } out_item_t;

  typedef struct packed {
    logic       c;
    logic       v;
    logic [7:0] res;
  } alu_res_t;

  // Update N and Z from a result byte.
  function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] val);
    logic [7:0] r;
    r        = p;
    r[FlagN] = val[7];
    r[FlagZ] = (val == 8'h00);
    return r;
  endfunction

  // Binary add with carry; carry out and signed overflow.
  function automatic alu_res_t add_c(logic [7:0] a, logic [7:0] m, logic cin);
    logic [8:0] sum;
    alu_res_t   r;
    sum   = {1'b0, a} + {1'b0, m} + {8'h00, cin};
    r.c   = sum[8];
    r.v   = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
    r.res = sum[7:0];
    return r;
  endfunction

  // Compare: carry is no borrow, result is the difference.
  function automatic alu_res_t cmp(logic [7:0] r8, logic [7:0] m);
    alu_res_t r;
    r.c   = (r8 >= m);
    r.v   = 1'b0;
    r.res = r8 - m;
    return r;
  endfunction

  // Shifts and rotates by one bit.
  function automatic alu_res_t shift1(shift_e kind, logic [7:0] val, logic cin);
    alu_res_t r;
    r.v = 1'b0;
    unique case (kind)
      SH_ASL: begin
        r.c   = val[7];
        r.res = {val[6:0], 1'b0};
      end
      SH_ROL: begin
        r.c   = val[7];
        r.res = {val[6:0], cin};
      end
      SH_LSR: begin
        r.c   = val[0];
        r.res = {1'b0, val[7:1]};
      end
      SH_ROR: begin
        r.c   = val[0];
        r.res = {cin, val[7:1]};
      end
      default: begin
        r.c   = 1'b0;
        r.res = val;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/core/mos6502_execute_unit.sv
// Top level of the 6502 execute unit: register file, ALU and stream handshake.
`include "mos6502_execute_unit_macros.svh"

// The unit executes one 6502 instruction step per request and keeps A, X, Y,
// SP and P in place. A request on the slave side is first captured in an
// input register; once the result register has room, the ALU and flag logic
// work on it and the register file and the result register load together. It
// sustains one request per clock as long as the result register is empty or
// its content is taken in the same cycle; otherwise the held request stalls.
// A result is presented from the result register, so a request passes the
// input register and then the result register before the receiver can take
// it. Decimal mode is stored in P but has no effect on ADC and SBC. Addressing,
// the program counter and cycle counts live outside this block; the write byte
// and strobe tell the surrounding logic what to store or push.
module mos6502_execute_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // action[5:0], operand[13:6], branch_condition[16:14], zero fill above
  input  logic [m65eu_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // write_data[7:0], write_strobe[8], branch_taken[9], acc_out[17:10],
  // x_out[25:18], y_out[33:26], flags_out[41:34], sp_out[49:42], zero fill above
  output logic [m65eu_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import m65eu_pkg::*;

  // Input register.
  logic      in_valid_q;
  in_item_t  in_q;

  // Result register.
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;

  // Architectural registers.
  logic [7:0] a_q, a_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] p_q, p_d;
  logic [7:0] sp_q, sp_d;

  logic exec_fire;
  logic in_fire;

  // The held request executes once the result register has room.
  assign exec_fire       = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || exec_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_item_t'(s_axis_tdata_i[$bits(in_item_t)-1:0]);
    end
  end

  // Execute: one pass through the ALU and flag logic.
  always_comb begin
    logic [7:0] m;
    logic [7:0] tmp;
    logic       flag_sel;
    alu_res_t   r1;
    alu_res_t   r2;

    m        = in_q.operand;
    tmp      = 8'h00;
    flag_sel = 1'b0;
    r1       = '0;
    r2       = '0;

    a_d  = a_q;
    x_d  = x_q;
    y_d  = y_q;
    p_d  = p_q;
    sp_d = sp_q;

    out_d              = '0;
    out_d.write_data   = 8'h00;
    out_d.write_strobe = 1'b0;
    out_d.branch_taken = 1'b0;

    unique case (action_e'(in_q.action))
      ACT_ADC, ACT_SBC: begin
        r1 = add_c(a_q, (in_q.action == ACT_SBC) ? ~m : m, p_q[FlagC]);
        a_d = r1.res;
        p_d = set_nz(p_q, r1.res);
        p_d[FlagC] = r1.c;
        p_d[FlagV] = r1.v;
      end
      ACT_AND: begin
        a_d = a_q & m;
        p_d = set_nz(p_q, a_q & m);
      end
      ACT_ORA: begin
        a_d = a_q | m;
        p_d = set_nz(p_q, a_q | m);
      end
      ACT_EOR: begin
        a_d = a_q ^ m;
        p_d = set_nz(p_q, a_q ^ m);
      end
      ACT_BIT: begin
        p_d[FlagZ] = ((a_q & m) == 8'h00);
        p_d[FlagN] = m[7];
        p_d[FlagV] = m[6];
      end
      ACT_CMP, ACT_CPX, ACT_CPY: begin
        if (in_q.action == ACT_CPX) begin
          tmp = x_q;
        end else if (in_q.action == ACT_CPY) begin
          tmp = y_q;
        end else begin
          tmp = a_q;
        end
        r1 = cmp(tmp, m);
        p_d = set_nz(p_q, r1.res);
        p_d[FlagC] = r1.c;
      end
      ACT_BRANCH: begin
        unique case (in_q.branch_condition[2:1])
          2'd0:    flag_sel = p_q[FlagZ];
          2'd1:    flag_sel = p_q[FlagN];
          2'd2:    flag_sel = p_q[FlagC];
          default: flag_sel = p_q[FlagV];
        endcase
        // Odd conditions branch when the flag is clear.
        out_d.branch_taken = flag_sel ^ in_q.branch_condition[0];
      end
      ACT_CLC: p_d[FlagC] = 1'b0;
      ACT_CLD: p_d[FlagD] = 1'b0;
      ACT_CLI: p_d[FlagI] = 1'b0;
      ACT_CLV: p_d[FlagV] = 1'b0;
      ACT_SEC: p_d[FlagC] = 1'b1;
      ACT_SED: p_d[FlagD] = 1'b1;
      ACT_SEI: p_d[FlagI] = 1'b1;
      ACT_JMP, ACT_NOP: begin
      end
      ACT_JSR: sp_d = sp_q - 8'd2;
      ACT_RTS: sp_d = sp_q + 8'd2;
      ACT_RTI: begin
        p_d  = (m & PulledMask) | (p_q & BuMask);
        sp_d = sp_q + 8'd3;
      end
      ACT_LDA: begin
        a_d = m;
        p_d = set_nz(p_q, m);
      end
      ACT_LDX: begin
        x_d = m;
        p_d = set_nz(p_q, m);
      end
      ACT_LDY: begin
        y_d = m;
        p_d = set_nz(p_q, m);
      end
      ACT_PHA: begin
        out_d.write_data   = a_q;
        out_d.write_strobe = 1'b1;
        sp_d = sp_q - 8'd1;
      end
      ACT_PHP: begin
        out_d.write_data   = p_q | BuMask;
        out_d.write_strobe = 1'b1;
        sp_d = sp_q - 8'd1;
      end
      ACT_PLA: begin
        a_d  = m;
        p_d  = set_nz(p_q, m);
        sp_d = sp_q + 8'd1;
      end
      ACT_PLP: begin
        p_d  = (m & PulledMask) | (p_q & BuMask);
        sp_d = sp_q + 8'd1;
      end
      ACT_STA: begin
        out_d.write_data   = a_q;
        out_d.write_strobe = 1'b1;
      end
      ACT_STX: begin
        out_d.write_data   = x_q;
        out_d.write_strobe = 1'b1;
      end
      ACT_STY: begin
        out_d.write_data   = y_q;
        out_d.write_strobe = 1'b1;
      end
      ACT_TAX: begin
        x_d = a_q;
        p_d = set_nz(p_q, a_q);
      end
      ACT_TAY: begin
        y_d = a_q;
        p_d = set_nz(p_q, a_q);
      end
      ACT_TSX: begin
        x_d = sp_q;
        p_d = set_nz(p_q, sp_q);
      end
      ACT_TXA: begin
        a_d = x_q;
        p_d = set_nz(p_q, x_q);
      end
      ACT_TXS: sp_d = x_q;
      ACT_TYA: begin
        a_d = y_q;
        p_d = set_nz(p_q, y_q);
      end
      ACT_INC: begin
        tmp = m + 8'd1;
        out_d.write_data   = tmp;
        out_d.write_strobe = 1'b1;
        p_d = set_nz(p_q, tmp);
      end
      ACT_INX: begin
        x_d = x_q + 8'd1;
        p_d = set_nz(p_q, x_q + 8'd1);
      end
      ACT_INY: begin
        y_d = y_q + 8'd1;
        p_d = set_nz(p_q, y_q + 8'd1);
      end
      ACT_DEC: begin
        tmp = m - 8'd1;
        out_d.write_data   = tmp;
        out_d.write_strobe = 1'b1;
        p_d = set_nz(p_q, tmp);
      end
      ACT_DEX: begin
        x_d = x_q - 8'd1;
        p_d = set_nz(p_q, x_q - 8'd1);
      end
      ACT_DEY: begin
        y_d = y_q - 8'd1;
        p_d = set_nz(p_q, y_q - 8'd1);
      end
      ACT_ASL_A, ACT_LSR_A, ACT_ROL_A, ACT_ROR_A: begin
        r1 = shift1(shift_e'(in_q.action[1:0] - 2'd3), a_q, p_q[FlagC]);
        a_d = r1.res;
        p_d = set_nz(p_q, r1.res);
        p_d[FlagC] = r1.c;
      end
      ACT_ASL_M, ACT_LSR_M, ACT_ROL_M, ACT_ROR_M: begin
        // Codes 47 to 50 map to the shift kinds by their low two bits plus one.
        r1 = shift1(shift_e'(in_q.action[1:0] + 2'd1), m, p_q[FlagC]);
        out_d.write_data   = r1.res;
        out_d.write_strobe = 1'b1;
        p_d = set_nz(p_q, r1.res);
        p_d[FlagC] = r1.c;
      end
      ACT_BRK: begin
        out_d.write_data   = p_q | BuMask;
        out_d.write_strobe = 1'b1;
        p_d[FlagI] = 1'b1;
        sp_d = sp_q - 8'd3;
      end
      ACT_LAX: begin
        a_d = m;
        x_d = m;
        p_d = set_nz(p_q, m);
      end
      ACT_SAX: begin
        out_d.write_data   = a_q & x_q;
        out_d.write_strobe = 1'b1;
      end
      ACT_DCP: begin
        tmp = m - 8'd1;
        out_d.write_data   = tmp;
        out_d.write_strobe = 1'b1;
        r1 = cmp(a_q, tmp);
        p_d = set_nz(p_q, r1.res);
        p_d[FlagC] = r1.c;
      end
      ACT_ISB: begin
        tmp = m + 8'd1;
        out_d.write_data   = tmp;
        out_d.write_strobe = 1'b1;
        r1 = add_c(a_q, ~tmp, p_q[FlagC]);
        a_d = r1.res;
        p_d = set_nz(p_q, r1.res);
        p_d[FlagC] = r1.c;
        p_d[FlagV] = r1.v;
      end
      ACT_RLA: begin
        r1 = shift1(SH_ROL, m, p_q[FlagC]);
        out_d.write_data   = r1.res;
        out_d.write_strobe = 1'b1;
        a_d = a_q & r1.res;
        p_d = set_nz(p_q, a_q & r1.res);
        p_d[FlagC] = r1.c;
      end
      ACT_RRA: begin
        // The rotate's carry out feeds the add.
        r1 = shift1(SH_ROR, m, p_q[FlagC]);
        out_d.write_data   = r1.res;
        out_d.write_strobe = 1'b1;
        r2 = add_c(a_q, r1.res, r1.c);
        a_d = r2.res;
        p_d = set_nz(p_q, r2.res);
        p_d[FlagC] = r2.c;
        p_d[FlagV] = r2.v;
      end
      ACT_SLO: begin
        r1 = shift1(SH_ASL, m, p_q[FlagC]);
        out_d.write_data   = r1.res;
        out_d.write_strobe = 1'b1;
        a_d = a_q | r1.res;
        p_d = set_nz(p_q, a_q | r1.res);
        p_d[FlagC] = r1.c;
      end
      ACT_SRE: begin
        r1 = shift1(SH_LSR, m, p_q[FlagC]);
        out_d.write_data   = r1.res;
        out_d.write_strobe = 1'b1;
        a_d = a_q ^ r1.res;
        p_d = set_nz(p_q, a_q ^ r1.res);
        p_d[FlagC] = r1.c;
      end
      default: begin
        // Unassigned codes behave as NOP.
      end
    endcase

    out_d.acc_out   = a_d;
    out_d.x_out     = x_d;
    out_d.y_out     = y_d;
    out_d.flags_out = p_d;
    out_d.sp_out    = sp_d;
  end

  // Register file updates in place when a request executes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= 8'h00;
      x_q  <= 8'h00;
      y_q  <= 8'h00;
      p_q  <= ResetFlags;
      sp_q <= ResetSp;
    end else if (exec_fire) begin
      a_q  <= a_d;
      x_q  <= x_d;
      y_q  <= y_d;
      p_q  <= p_d;
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(out_item_t)){1'b0}}, out_q};

  // The unused status bit is never cleared by any instruction.
  `EU_ASSERT(a_u_flag_set, p_q[5], "unused status bit cleared")
  // A result without a write strobe carries a zero write byte.
  `EU_ASSERT(a_wdata_zero, out_valid_q && !out_q.write_strobe |-> out_q.write_data == 8'h00, "write byte without strobe")
  // Only a branch test can report a taken branch.
  `EU_ASSERT(a_taken_branch_only, exec_fire && in_q.action != ACT_BRANCH |=> !out_q.branch_taken, "taken branch from a non-branch action")
  // The register file only moves when a request executes.
  `EU_ASSERT(a_regs_hold, !exec_fire |=> $stable(a_q) && $stable(x_q) && $stable(y_q) && $stable(p_q) && $stable(sp_q), "register file changed without a request")
  // The result register always mirrors the register file it was loaded with.
  `EU_ASSERT(a_result_matches_regs, exec_fire |=> out_q.acc_out == a_q && out_q.flags_out == p_q && out_q.sp_out == sp_q, "result register out of step with register file")

endmodule

### sim/mos6502_execute_unit_tb.sv
// Self-checking stream testbench for the 6502 execute unit with an in-line register model.
import m65eu_pkg::*;

// Holds a shadow copy of A, X, Y, P and SP, and works out each expected step.
class exec_step_checker;
  typedef enum logic [2:0] {
    BR_EQ, BR_NE, BR_MI, BR_PL, BR_CS, BR_CC, BR_VS, BR_VC
  } branch_e;

  logic [7:0]  acc;
  logic [7:0]  ix;
  logic [7:0]  iy;
  logic [7:0]  p;
  logic [7:0]  sp;
  out_item_t   expected_steps[$];
  int unsigned failures;

  function new();
    acc      = 8'h00;
    ix       = 8'h00;
    iy       = 8'h00;
    p        = ResetFlags;
    sp       = ResetSp;
    failures = 0;
  endfunction

  function int unsigned pending();
    return expected_steps.size();
  endfunction

  function void load_nz(logic [7:0] v);
    p[FlagN] = v[7];
    p[FlagZ] = (v == 8'h00);
  endfunction

  function logic [7:0] add_carry(logic [7:0] a, logic [7:0] m);
    logic [8:0] s;
    s        = {1'b0, a} + {1'b0, m} + {8'h00, p[FlagC]};
    p[FlagC] = s[8];
    p[FlagV] = (a[7] == m[7]) && (s[7] != a[7]);
    load_nz(s[7:0]);
    return s[7:0];
  endfunction

  function void compare_reg(logic [7:0] r, logic [7:0] m);
    p[FlagC] = (r >= m);
    load_nz(r - m);
  endfunction

  function logic [7:0] shift_byte(shift_e kind, logic [7:0] v);
    logic [7:0] r;
    case (kind)
      SH_ASL: r = {v[6:0], 1'b0};
      SH_ROL: r = {v[6:0], p[FlagC]};
      SH_LSR: r = {1'b0, v[7:1]};
      default: r = {p[FlagC], v[7:1]};
    endcase
    p[FlagC] = (kind == SH_ASL || kind == SH_ROL) ? v[7] : v[0];
    load_nz(r);
    return r;
  endfunction

  // Pulled status keeps the current B and U bits.
  function logic [7:0] pulled(logic [7:0] m);
    return (m & PulledMask) | (p & BuMask);
  endfunction

  function void predict_step(in_item_t req);
    out_item_t  e;
    logic [7:0] m;
    logic [7:0] v;
    e = '0;
    m = req.operand;
    case (action_e'(req.action))
      ACT_ADC: acc = add_carry(acc, m);
      ACT_SBC: acc = add_carry(acc, ~m);
      ACT_AND: begin acc = acc & m; load_nz(acc); end
      ACT_ORA: begin acc = acc | m; load_nz(acc); end
      ACT_EOR: begin acc = acc ^ m; load_nz(acc); end
      ACT_BIT: begin
        p[FlagZ] = ((acc & m) == 8'h00);
        p[FlagN] = m[7];
        p[FlagV] = m[6];
      end
      ACT_CMP: compare_reg(acc, m);
      ACT_CPX: compare_reg(ix, m);
      ACT_CPY: compare_reg(iy, m);
      ACT_BRANCH: begin
        case (branch_e'(req.branch_condition))
          BR_EQ: e.branch_taken = p[FlagZ];
          BR_NE: e.branch_taken = !p[FlagZ];
          BR_MI: e.branch_taken = p[FlagN];
          BR_PL: e.branch_taken = !p[FlagN];
          BR_CS: e.branch_taken = p[FlagC];
          BR_CC: e.branch_taken = !p[FlagC];
          BR_VS: e.branch_taken = p[FlagV];
          default: e.branch_taken = !p[FlagV];
        endcase
      end
      ACT_CLC: p[FlagC] = 1'b0;
      ACT_CLD: p[FlagD] = 1'b0;
      ACT_CLI: p[FlagI] = 1'b0;
      ACT_CLV: p[FlagV] = 1'b0;
      ACT_SEC: p[FlagC] = 1'b1;
      ACT_SED: p[FlagD] = 1'b1;
      ACT_SEI: p[FlagI] = 1'b1;
      ACT_JSR: sp = sp - 8'd2;
      ACT_RTS: sp = sp + 8'd2;
      ACT_RTI: begin p = pulled(m); sp = sp + 8'd3; end
      ACT_LDA: begin acc = m; load_nz(m); end
      ACT_LDX: begin ix = m; load_nz(m); end
      ACT_LDY: begin iy = m; load_nz(m); end
      ACT_PHA: begin e.write_data = acc; e.write_strobe = 1'b1; sp = sp - 8'd1; end
      ACT_PHP: begin
        e.write_data = p | BuMask; e.write_strobe = 1'b1; sp = sp - 8'd1;
      end
      ACT_PLA: begin acc = m; load_nz(m); sp = sp + 8'd1; end
      ACT_PLP: begin p = pulled(m); sp = sp + 8'd1; end
      ACT_STA: begin e.write_data = acc; e.write_strobe = 1'b1; end
      ACT_STX: begin e.write_data = ix; e.write_strobe = 1'b1; end
      ACT_STY: begin e.write_data = iy; e.write_strobe = 1'b1; end
      ACT_TAX: begin ix = acc; load_nz(ix); end
      ACT_TAY: begin iy = acc; load_nz(iy); end
      ACT_TSX: begin ix = sp; load_nz(ix); end
      ACT_TXA: begin acc = ix; load_nz(acc); end
      ACT_TXS: sp = ix;
      ACT_TYA: begin acc = iy; load_nz(acc); end
      ACT_INC: begin e.write_data = m + 8'd1; e.write_strobe = 1'b1; load_nz(e.write_data); end
      ACT_INX: begin ix = ix + 8'd1; load_nz(ix); end
      ACT_INY: begin iy = iy + 8'd1; load_nz(iy); end
      ACT_DEC: begin e.write_data = m - 8'd1; e.write_strobe = 1'b1; load_nz(e.write_data); end
      ACT_DEX: begin ix = ix - 8'd1; load_nz(ix); end
      ACT_DEY: begin iy = iy - 8'd1; load_nz(iy); end
      ACT_ASL_A: acc = shift_byte(SH_ASL, acc);
      ACT_LSR_A: acc = shift_byte(SH_LSR, acc);
      ACT_ROL_A: acc = shift_byte(SH_ROL, acc);
      ACT_ROR_A: acc = shift_byte(SH_ROR, acc);
      ACT_ASL_M: begin e.write_data = shift_byte(SH_ASL, m); e.write_strobe = 1'b1; end
      ACT_LSR_M: begin e.write_data = shift_byte(SH_LSR, m); e.write_strobe = 1'b1; end
      ACT_ROL_M: begin e.write_data = shift_byte(SH_ROL, m); e.write_strobe = 1'b1; end
      ACT_ROR_M: begin e.write_data = shift_byte(SH_ROR, m); e.write_strobe = 1'b1; end
      ACT_BRK: begin
        e.write_data   = p | BuMask;
        e.write_strobe = 1'b1;
        p[FlagI]       = 1'b1;
        sp             = sp - 8'd3;
      end
      ACT_LAX: begin acc = m; ix = m; load_nz(m); end
      ACT_SAX: begin e.write_data = acc & ix; e.write_strobe = 1'b1; end
      ACT_DCP: begin
        v = m - 8'd1;
        e.write_data = v; e.write_strobe = 1'b1;
        compare_reg(acc, v);
      end
      ACT_ISB: begin
        v = m + 8'd1;
        e.write_data = v; e.write_strobe = 1'b1;
        acc = add_carry(acc, ~v);
      end
      ACT_RLA: begin
        v = shift_byte(SH_ROL, m);
        e.write_data = v; e.write_strobe = 1'b1;
        acc = acc & v; load_nz(acc);
      end
      ACT_RRA: begin
        // The rotate's carry out feeds the add.
        v = shift_byte(SH_ROR, m);
        e.write_data = v; e.write_strobe = 1'b1;
        acc = add_carry(acc, v);
      end
      ACT_SLO: begin
        v = shift_byte(SH_ASL, m);
        e.write_data = v; e.write_strobe = 1'b1;
        acc = acc | v; load_nz(acc);
      end
      ACT_SRE: begin
        v = shift_byte(SH_LSR, m);
        e.write_data = v; e.write_strobe = 1'b1;
        acc = acc ^ v; load_nz(acc);
      end
      default: ;  // NOP, JMP and unassigned codes leave everything alone.
    endcase
    e.acc_out   = acc;
    e.x_out     = ix;
    e.y_out     = iy;
    e.flags_out = p;
    e.sp_out    = sp;
    expected_steps.push_back(e);
  endfunction

  function void compare_field(string name, logic [7:0] expv, logic [7:0] gotv);
    if (gotv !== expv) begin
      $error("%s: expected %0h, got %0h", name, expv, gotv);
      failures++;
    end
  endfunction

  function void check_step(out_item_t got);
    out_item_t e;
    if (expected_steps.size() == 0) begin
      $error("result with no request outstanding: %0h", got);
      failures++;
      return;
    end
    e = expected_steps.pop_front();
    compare_field("write_data", e.write_data, got.write_data);
    compare_field("write_strobe", 8'(e.write_strobe), 8'(got.write_strobe));
    compare_field("branch_taken", 8'(e.branch_taken), 8'(got.branch_taken));
    compare_field("acc_out", e.acc_out, got.acc_out);
    compare_field("x_out", e.x_out, got.x_out);
    compare_field("y_out", e.y_out, got.y_out);
    compare_field("flags_out", e.flags_out, got.flags_out);
    compare_field("sp_out", e.sp_out, got.sp_out);
  endfunction
endclass

module mos6502_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  exec_step_checker step_chk = new();

  mos6502_execute_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // The receiver decides its ready for the next edge at every edge, so a
  // stall can land on any phase of a result's life.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both handshakes are sampled here, at the edge, from values settled
  // before it. A request updates the shadow registers when it is taken;
  // a result is checked against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        step_chk.predict_step(in_item_t'(s_axis_tdata_i[$bits(in_item_t)-1:0]));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        step_chk.check_step(out_item_t'(m_axis_tdata_o[$bits(out_item_t)-1:0]));
      end
    end
  end

  // Offers one request and returns at the edge that takes it. Valid stays
  // high on return so that back-to-back requests need no extra assignment.
  task automatic send_request(logic [5:0] action, logic [7:0] operand, logic [2:0] cond);
    in_item_t           req;
    logic [InDataW-1:0] word;
    req.action           = action;
    req.operand          = operand;
    req.branch_condition = cond;
    word                 = '0;
    word[$bits(in_item_t)-1:0] = req;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (step_chk.pending() != 0);
  endtask

  // Operand bytes favor the corners where carries, signs and zeros flip.
  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(3) == 0) return corners[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [7:0]  sweep_operands[4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    logic [5:0]  act;
    int unsigned phase_idle[4]  = '{0, 67, 0, 9};
    int unsigned phase_stall[4] = '{0, 0, 67, 9};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every code once, including the unassigned ones, with extreme operands;
    // the branch code is sent with one branch condition only.
    for (int c = 0; c < 64; c++) begin
      send_request(6'(c), sweep_operands[c % 4], 3'(c));
    end

    // Signed overflow in both directions, then stack pointer wrap through
    // zero, the pushed status of BRK, and a pulled status that tries to
    // change B and U.
    send_request(ACT_LDA, 8'h7F, 3'd0);
    send_request(ACT_CLC, 8'h00, 3'd0);
    send_request(ACT_ADC, 8'h01, 3'd0);
    send_request(ACT_SEC, 8'h00, 3'd0);
    send_request(ACT_SBC, 8'h01, 3'd0);
    send_request(ACT_LDX, 8'h00, 3'd0);
    send_request(ACT_TXS, 8'h00, 3'd0);
    send_request(ACT_PHA, 8'h00, 3'd0);
    send_request(ACT_PLA, 8'h00, 3'd0);
    send_request(ACT_PLA, 8'h00, 3'd0);
    send_request(ACT_BRK, 8'h00, 3'd0);
    send_request(ACT_PLP, 8'hFF, 3'd0);
    send_request(ACT_PHP, 8'h00, 3'd0);
    send_request(ACT_RTI, 8'h00, 3'd0);
    send_request(ACT_TSX, 8'h00, 3'd0);
    send_request(ACT_BIT, 8'hC0, 3'd6);
    drain_results();

    // Random phases with different idle and stall mixes. Each phase ends
    // with the sender held off until the unit has nothing outstanding.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      repeat (325) begin
        if ($urandom_range(99) < 3) act = 6'($urandom_range(63, ACT_SRE + 1));
        else act = 6'($urandom_range(ACT_SRE));
        send_request(act, pick_operand(), 3'($urandom_range(7)));
      end
      drain_results();
    end

    // Give a stray late result the chance to show up.
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    if (step_chk.failures == 0 && step_chk.pending() == 0) begin
      $display("mos6502_execute_unit regression: pass");
    end else begin
      $display("mos6502_execute_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mos6502_execute_unit regression: fail");
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/m65eu_pkg.sv
rtl/core/mos6502_execute_unit.sv
sim/mos6502_execute_unit_tb.sv
